// ----- hw/rtl/rtpp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtpp_pkg
// Shared types, status codes and sizing constants for the RTP header parser.
// ----------------------------------------------------------------------------
package rtpp_pkg;

  // default and sizing constants
  localparam int MAX_PACKET_DEF = 4096;
  localparam int FIXED_HDR_LEN  = 12;
  // widest header size: 12 + 4*15 + 4 + 4*65535 fits in 19 bits
  localparam int HS_W           = 19;
  localparam int LEN_OUT_W      = 13;

  // result status codes
  localparam logic [3:0] ST_OK        = 4'd0;
  localparam logic [3:0] ST_SHORT     = 4'd1;
  localparam logic [3:0] ST_VERSION   = 4'd2;
  localparam logic [3:0] ST_EXT_HDR   = 4'd3;
  localparam logic [3:0] ST_EXT_DATA  = 4'd4;
  localparam logic [3:0] ST_PAD_EMPTY = 4'd5;
  localparam logic [3:0] ST_PAD_ZERO  = 4'd6;
  localparam logic [3:0] ST_PAD_LARGE = 4'd7;
  localparam logic [3:0] ST_OVERLEN   = 4'd8;

  localparam logic [1:0] RTP_VERSION  = 2'd2;

  // captured header fields
  typedef struct packed {
    logic [7:0]  first_byte;
    logic [7:0]  second_byte;
    logic [15:0] seq;
    logic [31:0] stamp;
    logic [31:0] source;
    logic [15:0] ext_words;
  } hdr_t;

endpackage

// ----- hw/rtl/rtpp_capture.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtpp_capture
// Byte counter and header field capture registers. Presents the fields as
// they stand after the current byte has been taken in.
// ----------------------------------------------------------------------------
module rtpp_capture
  import rtpp_pkg::*;
#(
  parameter int MAX_PACKET = MAX_PACKET_DEF,
  parameter int CNT_W      = $clog2(MAX_PACKET + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic [7:0]       data_byte,
  input  logic             last_byte,
  output logic [CNT_W-1:0] pos,
  output hdr_t             hdr_nxt
);

  localparam int CMP_W = (CNT_W > HS_W) ? CNT_W : HS_W;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PACKET);

  logic [CNT_W-1:0] count_r, count_nxt;
  hdr_t             hdr_r;
  logic [CMP_W-1:0] pos_w;
  logic [CMP_W-1:0] ext_pos;
  logic             in_range;

  assign pos      = count_r;
  assign pos_w    = CMP_W'(count_r);
  assign in_range = (count_r < MAX_CNT);
  // extension length word sits at bytes 2..3 of the extension header
  assign ext_pos  = CMP_W'(FIXED_HDR_LEN + 2) + CMP_W'({hdr_r.first_byte[3:0], 2'b00});

  always_comb begin
    hdr_nxt   = hdr_r;
    count_nxt = count_r;
    if (in_range) begin
      count_nxt = count_r + CNT_W'(1);
      if (pos_w == CMP_W'(0)) begin
        hdr_nxt.first_byte = data_byte;
      end else if (pos_w == CMP_W'(1)) begin
        hdr_nxt.second_byte = data_byte;
      end else if (pos_w < CMP_W'(4)) begin
        hdr_nxt.seq = {hdr_r.seq[7:0], data_byte};
      end else if (pos_w < CMP_W'(8)) begin
        hdr_nxt.stamp = {hdr_r.stamp[23:0], data_byte};
      end else if (pos_w < CMP_W'(FIXED_HDR_LEN)) begin
        hdr_nxt.source = {hdr_r.source[23:0], data_byte};
      end
      if (pos_w >= CMP_W'(FIXED_HDR_LEN) &&
          (pos_w == ext_pos || pos_w == ext_pos + CMP_W'(1))) begin
        hdr_nxt.ext_words = {hdr_r.ext_words[7:0], data_byte};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      hdr_r   <= '0;
    end else if (step) begin
      if (last_byte) begin
        // packet done, start over clean
        count_r <= '0;
        hdr_r   <= '0;
      end else begin
        count_r <= count_nxt;
        hdr_r   <= hdr_nxt;
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= MAX_CNT)
    else $error("byte counter past max packet");

  a_cnt_clear: assert property (@(posedge clk) disable iff (!rst_n)
    step && last_byte |=> count_r == '0 && hdr_r == '0)
    else $error("state not cleared after last byte");

  a_cnt_inc: assert property (@(posedge clk) disable iff (!rst_n)
    step && !last_byte && in_range |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("byte counter missed a byte");

endmodule

// ----- hw/rtl/rtpp_check.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtpp_check
// End-of-packet validation: header size, version, extension room and padding,
// giving the status and the header and payload offsets.
// ----------------------------------------------------------------------------
module rtpp_check
  import rtpp_pkg::*;
#(
  parameter int MAX_PACKET = MAX_PACKET_DEF,
  parameter int CNT_W      = $clog2(MAX_PACKET + 1)
) (
  input  logic [CNT_W-1:0]     pos,
  input  logic [7:0]           pad,
  input  hdr_t                 hdr,
  output logic [3:0]           status,
  output logic [LEN_OUT_W-1:0] header_length,
  output logic [LEN_OUT_W-1:0] payload_stop
);

  localparam int LEN_W = ((CNT_W > HS_W) ? CNT_W : HS_W) + 1;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PACKET);

  logic [LEN_W-1:0] len, hs_a, hs_b, room, stop_full;
  logic             pad_on, ext_on;

  assign pad_on    = hdr.first_byte[5];
  assign ext_on    = hdr.first_byte[4];
  assign len       = LEN_W'(pos) + LEN_W'(1);
  assign hs_a      = LEN_W'(FIXED_HDR_LEN) + LEN_W'({hdr.first_byte[3:0], 2'b00})
                   + (ext_on ? LEN_W'(4) : LEN_W'(0));
  assign hs_b      = hs_a + (ext_on ? LEN_W'({hdr.ext_words, 2'b00}) : LEN_W'(0));
  assign room      = len - hs_b;
  assign stop_full = pad_on ? (len - LEN_W'(pad)) : len;

  always_comb begin
    status        = ST_OK;
    header_length = '0;
    payload_stop  = '0;
    priority if (pos >= MAX_CNT) begin
      status = ST_OVERLEN;
    end else if (len < LEN_W'(FIXED_HDR_LEN)) begin
      status = ST_SHORT;
    end else if (hdr.first_byte[7:6] != RTP_VERSION) begin
      status = ST_VERSION;
    end else if (len < hs_a) begin
      status = ST_EXT_HDR;
    end else if (len < hs_b) begin
      status = ST_EXT_DATA;
    end else if (pad_on && len == hs_b) begin
      status = ST_PAD_EMPTY;
    end else if (pad_on && pad == 8'd0) begin
      status = ST_PAD_ZERO;
    end else if (pad_on && room < LEN_W'(pad)) begin
      status = ST_PAD_LARGE;
    end else begin
      header_length = hs_b[LEN_OUT_W-1:0];
      payload_stop  = stop_full[LEN_OUT_W-1:0];
    end
  end

endmodule

// ----- hw/rtl/rtp_packet_header_parser_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtp_packet_header_parser_core
// Byte-stream RTP header parser: captures the fixed header fields and the
// extension length, validates the packet on its last byte, emits one result.
// ----------------------------------------------------------------------------
// Takes one packet byte per clock, back to back, with in_last_byte on the
// final byte of each packet. Every byte passes an input register and is
// folded into the byte counter and capture registers as it leaves that
// register; on the last byte the validation runs in that same cycle and
// the result lands in the output register, which raises out_valid. Bytes
// that are not last never wait on the result side; a last byte waits only
// while an earlier result is still held. Packets longer than MAX_PACKET
// bytes report overlength and the bytes beyond it are ignored.
// ----------------------------------------------------------------------------
module rtp_packet_header_parser_core
  import rtpp_pkg::*;
#(
  parameter int MAX_PACKET = MAX_PACKET_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_data_byte,
  input  logic                 in_last_byte,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [3:0]           out_status,
  output logic [31:0]          out_source_id,
  output logic [15:0]          out_sequence_number,
  output logic [31:0]          out_time_stamp,
  output logic                 out_marker_bit,
  output logic [6:0]           out_payload_kind,
  output logic [LEN_OUT_W-1:0] out_header_length,
  output logic [LEN_OUT_W-1:0] out_payload_start,
  output logic [LEN_OUT_W-1:0] out_payload_stop
);

  localparam int CNT_W = $clog2(MAX_PACKET + 1);

  logic                 in_valid_r;
  logic [7:0]           in_byte_r;
  logic                 in_last_r;
  logic                 advance, step;
  logic [CNT_W-1:0]     pos;
  hdr_t                 hdr_nxt;
  logic [3:0]           status;
  logic [LEN_OUT_W-1:0] hlen, stop;

  logic                 out_valid_r;
  logic [3:0]           status_r;
  hdr_t                 hdr_out_r;
  logic [LEN_OUT_W-1:0] hlen_r, stop_r;

  // only a last byte needs room in the result register
  assign advance  = !in_last_r || !out_valid_r || out_ready;
  assign step     = in_valid_r && advance;
  assign in_ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_byte_r <= in_data_byte;
      in_last_r <= in_last_byte;
    end
  end

  rtpp_capture #(
    .MAX_PACKET (MAX_PACKET),
    .CNT_W      (CNT_W)
  ) u_capture (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .data_byte (in_byte_r),
    .last_byte (in_last_r),
    .pos       (pos),
    .hdr_nxt   (hdr_nxt)
  );

  rtpp_check #(
    .MAX_PACKET (MAX_PACKET),
    .CNT_W      (CNT_W)
  ) u_check (
    .pos           (pos),
    .pad           (in_byte_r),
    .hdr           (hdr_nxt),
    .status        (status),
    .header_length (hlen),
    .payload_stop  (stop)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step && in_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && in_last_r) begin
      status_r  <= status;
      hdr_out_r <= hdr_nxt;
      hlen_r    <= hlen;
      stop_r    <= stop;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = status_r;
  assign out_source_id       = hdr_out_r.source;
  assign out_sequence_number = hdr_out_r.seq;
  assign out_time_stamp      = hdr_out_r.stamp;
  assign out_marker_bit      = hdr_out_r.second_byte[7];
  assign out_payload_kind    = hdr_out_r.second_byte[6:0];
  assign out_header_length   = hlen_r;
  assign out_payload_start   = hlen_r;
  assign out_payload_stop    = stop_r;

  a_bad_zero_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && status_r != ST_OK |-> hlen_r == '0 && stop_r == '0)
    else $error("lengths nonzero on failed packet");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r && $stable(status_r) && $stable(hlen_r))
    else $error("pending result overwritten");

  a_input_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !advance |=> in_valid_r && $stable(in_byte_r) && $stable(in_last_r))
    else $error("stalled input request lost");

endmodule
